// File: src/gtp_pkg.sv
// gtp_pkg: shared types and constants for the guid hex text parser
// no dependencies; used by all parser modules and the bench

package gtp_pkg;

  localparam int unsigned CountW = 6;

  localparam logic [CountW-1:0] DigitsNeeded = 6'd32;
  localparam logic [CountW-1:0] CountSat     = 6'd33;

  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChHyphen = 8'h2d;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChUpX    = 8'h58;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;

  typedef struct packed {
    logic       is_sep;
    logic       is_zero;
    logic       is_x;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_class_t;

  typedef struct packed {
    logic        parse_ok;
    logic [31:0] time_low;
    logic [15:0] time_mid;
    logic [15:0] time_high;
    logic [63:0] tail_bytes;
  } guid_t;

endpackage

// File: src/gtp_char_if.sv
// gtp_char_if: valid/ready channel carrying one text character per word
// no dependencies

interface gtp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: src/gtp_guid_if.sv
// gtp_guid_if: valid/ready channel carrying one parsed guid per word
// no dependencies

interface gtp_guid_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [31:0] time_low;
  logic [15:0] time_mid;
  logic [15:0] time_high;
  logic [63:0] tail_bytes;

  modport source (
    output valid, output parse_ok, output time_low, output time_mid,
    output time_high, output tail_bytes, input ready
  );
  modport sink (
    input valid, input parse_ok, input time_low, input time_mid,
    input time_high, input tail_bytes, output ready
  );
endinterface

// File: src/gtp_char_decode.sv
// gtp_char_decode: classifies one ascii byte as separator, zero, x or hex digit
// depends on gtp_pkg

module gtp_char_decode import gtp_pkg::*; (
  input  logic [7:0]  char_code_i,
  output char_class_t class_o
);

  logic is_dec;
  logic is_lower;
  logic is_upper;

  always_comb begin
    is_dec   = (char_code_i >= ChZero) && (char_code_i <= ChNine);
    is_lower = (char_code_i >= ChLowA) && (char_code_i <= ChLowF);
    is_upper = (char_code_i >= ChUpA) && (char_code_i <= ChUpF);

    class_o.is_sep  = (char_code_i == ChSpace) || (char_code_i == ChLParen) ||
                      (char_code_i == ChRParen) || (char_code_i == ChLBrace) ||
                      (char_code_i == ChRBrace) || (char_code_i == ChHyphen) ||
                      (char_code_i == ChComma);
    class_o.is_zero = (char_code_i == ChZero);
    class_o.is_x    = (char_code_i == ChLowX) || (char_code_i == ChUpX);
    class_o.is_hex  = is_dec || is_lower || is_upper;

    // letters a-f and A-F have low nibble 1..6
    if (is_dec) begin
      class_o.hex_val = char_code_i[3:0];
    end else begin
      class_o.hex_val = char_code_i[3:0] + 4'd9;
    end
  end

endmodule

// File: src/gtp_parse_core.sv
// gtp_parse_core: digit store, count and flags, updated once per character
// depends on gtp_pkg

module gtp_parse_core import gtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  char_class_t class_i,
  input  logic        last_char_i,
  output guid_t       result_o
);

  logic [127:0]      store_q, store_d;
  logic [CountW-1:0] count_q, count_d;
  logic              bad_q, bad_d;
  logic              pend_q, pend_d;

  logic              consumed;
  logic              pend_push;
  logic              new_pend;
  logic              digit_push;
  logic              tail_push;
  logic              second_push;
  logic [3:0]        second_val;
  logic [1:0]        n_push;
  logic [CountW-1:0] count_sum;

  always_comb begin
    consumed    = pend_q && class_i.is_x;
    pend_push   = pend_q && !class_i.is_x;
    new_pend    = !consumed && class_i.is_zero;
    digit_push  = !consumed && class_i.is_hex && !class_i.is_zero;
    tail_push   = last_char_i && new_pend;
    second_push = digit_push || tail_push;
    second_val  = digit_push ? class_i.hex_val : 4'h0;

    bad_d  = bad_q || (!consumed && !class_i.is_sep && !class_i.is_hex);
    pend_d = new_pend && !last_char_i;

    if (pend_push && second_push) begin
      store_d = {store_q[119:0], 4'h0, second_val};
    end else if (pend_push) begin
      store_d = {store_q[123:0], 4'h0};
    end else if (second_push) begin
      store_d = {store_q[123:0], second_val};
    end else begin
      store_d = store_q;
    end

    n_push    = {1'b0, pend_push} + {1'b0, second_push};
    count_sum = count_q + {{(CountW-2){1'b0}}, n_push};
    count_d   = (count_sum > CountSat) ? CountSat : count_sum;

    result_o.parse_ok = !bad_d && (count_d == DigitsNeeded);
    if (result_o.parse_ok) begin
      result_o.time_low   = store_d[127:96];
      result_o.time_mid   = store_d[95:80];
      result_o.time_high  = store_d[79:64];
      result_o.tail_bytes = store_d[63:0];
    end else begin
      result_o.time_low   = '0;
      result_o.time_mid   = '0;
      result_o.time_high  = '0;
      result_o.tail_bytes = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      count_q <= '0;
      bad_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else if (advance_i) begin
      if (last_char_i) begin
        store_q <= '0;
        count_q <= '0;
        bad_q   <= 1'b0;
        pend_q  <= 1'b0;
      end else begin
        store_q <= store_d;
        count_q <= count_d;
        bad_q   <= bad_d;
        pend_q  <= pend_d;
      end
    end
  end

endmodule

// File: src/guid_hex_text_parser_top.sv
// guid_hex_text_parser_top: input register, character decode, parse core, result register
// depends on gtp_pkg, gtp_char_if, gtp_guid_if, gtp_char_decode, gtp_parse_core

// Takes a GUID text one character per word on char_i, the final character
// marked by last_char, and gives one word on guid_o per text. Separators
// (space, parentheses, braces, hyphen, comma) are skipped and "0x"/"0X"
// prefixes are dropped; any other non-hex byte makes the result not ok.
// parse_ok is set only for exactly 32 hex digits with no bad byte, and all
// fields are zero otherwise. One character is taken every cycle unless input
// stalls; each waits in the input register, and a result is loaded into the output
// register as its last character leaves the input register. Input stalls only
// when a last character meets a result that has not yet been taken.

module guid_hex_text_parser_top import gtp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  gtp_char_if.sink   char_i,
  gtp_guid_if.source guid_o
);

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        last_q;
  logic        out_valid_q;
  guid_t       out_q;

  char_class_t char_class;
  guid_t       result;
  logic        out_free;
  logic        advance;

  assign out_free     = !out_valid_q || guid_o.ready;
  assign advance      = in_valid_q && (!last_q || out_free);
  assign char_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (char_i.valid && char_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      char_q <= char_i.char_code;
      last_q <= char_i.last_char;
    end
  end

  gtp_char_decode u_decode (
    .char_code_i (char_q),
    .class_o     (char_class)
  );

  gtp_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .class_i     (char_class),
    .last_char_i (last_q),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (guid_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      out_q <= result;
    end
  end

  assign guid_o.valid      = out_valid_q;
  assign guid_o.parse_ok   = out_q.parse_ok;
  assign guid_o.time_low   = out_q.time_low;
  assign guid_o.time_mid   = out_q.time_mid;
  assign guid_o.time_high  = out_q.time_high;
  assign guid_o.tail_bytes = out_q.tail_bytes;

endmodule

// File: verif/guid_hex_text_parser_top_tb.sv
// guid_hex_text_parser_top_tb: self-checking bench for the guid hex text parser
// drives texts one character per word and checks each parsed guid against a predictor
// depends on gtp_pkg, gtp_char_if, gtp_guid_if and guid_hex_text_parser_top

module guid_hex_text_parser_top_tb import gtp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned ItemsWanted   = 500;
  localparam int unsigned TextsPerPhase = 4;

  localparam guid_t NoGuid = '0;

  typedef enum int unsigned {FillMixed, FillOnes, FillZeros} fill_e;
  typedef enum int unsigned {StylePlain, StyleHyphen, StyleBraced, StyleStruct} guid_style_e;
  typedef enum int unsigned {BreakDrop, BreakJunk, BreakDigit, BreakLoneX} break_e;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    guid_t      want;
  } char_row_t;

  localparam char_row_t DirRows [24] = '{
    '{8'hff,    1'b1, NoGuid},
    '{8'h00,    1'b1, NoGuid},
    '{ChZero,   1'b1, NoGuid},
    '{ChUpX,    1'b1, NoGuid},
    '{ChZero,   1'b0, NoGuid},
    '{ChLowX,   1'b0, NoGuid},
    '{8'h31,    1'b1, NoGuid},
    '{ChZero,   1'b0, NoGuid},
    '{ChUpX,    1'b0, NoGuid},
    '{ChZero,   1'b1, NoGuid},
    '{ChSpace,  1'b0, NoGuid},
    '{ChLParen, 1'b0, NoGuid},
    '{ChRParen, 1'b0, NoGuid},
    '{ChLBrace, 1'b0, NoGuid},
    '{ChRBrace, 1'b0, NoGuid},
    '{ChHyphen, 1'b0, NoGuid},
    '{ChComma,  1'b0, NoGuid},
    '{ChUpF,    1'b1, NoGuid},
    '{ChZero,   1'b0, NoGuid},
    '{ChZero,   1'b1, NoGuid},
    '{ChLowF,   1'b0, NoGuid},
    '{8'h67,    1'b1, NoGuid},
    '{ChLowX,   1'b0, NoGuid},
    '{ChZero,   1'b1, NoGuid}
  };

  localparam int unsigned SendIdle [3] = '{22, 69, 0};
  localparam int unsigned RecvIdle [3] = '{69, 22, 0};

  logic clk_i;
  logic rst_ni;

  gtp_char_if char_if ();
  gtp_guid_if guid_if ();

  guid_hex_text_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .guid_o (guid_if)
  );

  // predictor state
  logic [127:0] nib_store;
  logic [5:0]   digit_cnt;
  logic         bad_seen;
  logic         zero_held;

  guid_t       guid_q [$];
  guid_t       pinned_q [$];
  logic [7:0]  text_q [$];

  int unsigned err_count;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned hold_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  function automatic bit is_skip(input logic [7:0] c);
    return c inside {ChSpace, ChLParen, ChRParen, ChLBrace, ChRBrace, ChHyphen, ChComma};
  endfunction

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) return {1'b1, 4'(c - ChZero)};
    if (c >= ChLowA && c <= ChLowF) return {1'b1, 4'(c - ChLowA + 8'd10)};
    if (c >= ChUpA && c <= ChUpF) return {1'b1, 4'(c - ChUpA + 8'd10)};
    return 5'd0;
  endfunction

  task automatic clear_parser();
    nib_store = '0;
    digit_cnt = '0;
    bad_seen  = 1'b0;
    zero_held = 1'b0;
  endtask

  task automatic push_digit(input logic [3:0] v);
    nib_store = {nib_store[123:0], v};
    if (digit_cnt < CountSat) digit_cnt++;
  endtask

  task automatic parse_char(input logic [7:0] c, input logic last,
                            output bit done, output guid_t res);
    logic [4:0] d;
    bit         eaten;
    eaten = 1'b0;
    done  = 1'b0;
    res   = NoGuid;
    d     = digit_of(c);
    if (zero_held) begin
      zero_held = 1'b0;
      if (c == ChLowX || c == ChUpX) eaten = 1'b1;
      else push_digit(4'h0);
    end
    if (!eaten && !is_skip(c)) begin
      if (c == ChZero) zero_held = 1'b1;
      else if (d[4]) push_digit(d[3:0]);
      else bad_seen = 1'b1;
    end
    if (last) begin
      if (zero_held) push_digit(4'h0);
      done = 1'b1;
      if (!bad_seen && digit_cnt == DigitsNeeded) begin
        res.parse_ok   = 1'b1;
        res.time_low   = nib_store[127:96];
        res.time_mid   = nib_store[95:80];
        res.time_high  = nib_store[79:64];
        res.tail_bytes = nib_store[63:0];
      end
      clear_parser();
    end
  endtask

  task automatic check_guid(input guid_t got);
    guid_t want;
    if (guid_q.size() == 0) begin
      report_mismatch("guid with nothing expected", 64'(got.parse_ok), '0);
      return;
    end
    want = guid_q.pop_front();
    if (got.parse_ok !== want.parse_ok)
      report_mismatch("parse_ok", 64'(got.parse_ok), 64'(want.parse_ok));
    if (got.time_low !== want.time_low)
      report_mismatch("time_low", 64'(got.time_low), 64'(want.time_low));
    if (got.time_mid !== want.time_mid)
      report_mismatch("time_mid", 64'(got.time_mid), 64'(want.time_mid));
    if (got.time_high !== want.time_high)
      report_mismatch("time_high", 64'(got.time_high), 64'(want.time_high));
    if (got.tail_bytes !== want.tail_bytes)
      report_mismatch("tail_bytes", got.tail_bytes, want.tail_bytes);
  endtask

  always @(posedge clk_i) begin : watch_ch
    bit    done;
    bit    moved;
    guid_t res;
    guid_t got;
    if (!rst_ni) begin
      clear_parser();
      quiet_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (char_if.valid && char_if.ready) begin
        moved = 1'b1;
        parse_char(char_if.char_code, char_if.last_char, done, res);
        if (done) begin
          if (pinned_q.size() > 0) res = pinned_q.pop_front();
          guid_q.push_back(res);
        end
      end
      if (guid_if.valid && guid_if.ready) begin
        moved          = 1'b1;
        got.parse_ok   = guid_if.parse_ok;
        got.time_low   = guid_if.time_low;
        got.time_mid   = guid_if.time_mid;
        got.time_high  = guid_if.time_high;
        got.tail_bytes = guid_if.tail_bytes;
        check_guid(got);
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // receiver: random stalls plus one long hold on request
  initial begin
    guid_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        guid_if.ready <= 1'b0;
        hold_left--;
      end else begin
        guid_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("[guid_hex_text_parser_top] ERROR");
    $finish;
  end

  task automatic drive_char(input logic [7:0] code, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      char_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= code;
    char_if.last_char <= last;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[k]) drive_char(text_q[k], k == text_q.size() - 1);
  endtask

  function automatic logic [7:0] hex_char(input fill_e fill);
    logic [3:0] v;
    case (fill)
      FillOnes:  v = 4'hf;
      FillZeros: v = 4'h0;
      default:   v = 4'($urandom_range(15));
    endcase
    if (v < 4'd10) return ChZero + 8'(v);
    return ($urandom_range(1) ? ChLowA : ChUpA) + 8'(v) - 8'd10;
  endfunction

  task automatic build_guid_text();
    int unsigned grp_len [$];
    fill_e       fill;
    guid_style_e style;
    int unsigned pick;
    int unsigned pos;
    pick  = $urandom_range(9);
    fill  = (pick == 0) ? FillOnes : (pick == 1) ? FillZeros : FillMixed;
    style = guid_style_e'($urandom_range(3));
    text_q.delete();
    if (style == StyleStruct) grp_len = '{8, 4, 4, 2, 2, 2, 2, 2, 2, 2, 2};
    else grp_len = '{8, 4, 4, 4, 12};
    if (style inside {StyleBraced, StyleStruct}) text_q.push_back(ChLBrace);
    foreach (grp_len[g]) begin
      if (style == StyleStruct) begin
        if (g > 0) text_q.push_back(ChComma);
        if (g == 3) text_q.push_back(ChLBrace);
        text_q.push_back(ChZero);
        text_q.push_back($urandom_range(1) ? ChLowX : ChUpX);
      end else if (style != StylePlain && g > 0) begin
        text_q.push_back(ChHyphen);
      end
      repeat (grp_len[g]) text_q.push_back(hex_char(fill));
    end
    if (style == StyleStruct) text_q.push_back(ChRBrace);
    if (style inside {StyleBraced, StyleStruct}) text_q.push_back(ChRBrace);
    if ($urandom_range(3) == 0) begin
      pos = $urandom_range(text_q.size() - 1);
      case (break_e'($urandom_range(3)))
        BreakDrop:  text_q.delete(pos);
        BreakJunk:  text_q.insert(pos, 8'($urandom_range(255)));
        BreakDigit: text_q.insert(pos, hex_char(FillMixed));
        BreakLoneX: text_q.insert(pos, ChLowX);
      endcase
    end
  endtask

  task automatic build_noise_text();
    logic [7:0]  spice [$];
    int unsigned len;
    spice = '{ChSpace, ChLParen, ChRParen, ChLBrace, ChRBrace, ChHyphen, ChComma,
              ChZero, ChLowX, ChUpX, 8'h00};
    len   = $urandom_range(20, 1);
    text_q.delete();
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(3))
        0, 1:    text_q.push_back(8'($urandom_range(255)));
        2:       text_q.push_back(hex_char(FillMixed));
        default: text_q.push_back(spice[$urandom_range(spice.size() - 1)]);
      endcase
    end
  endtask

  initial begin
    int unsigned texts_done;
    rst_ni            <= 1'b0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    char_if.last_char <= 1'b0;
    err_count     = 0;
    items_sent    = 0;
    hold_asked    = 0;
    hold_served   = 0;
    hold_left     = 0;
    send_idle_pct = SendIdle[0];
    recv_idle_pct = RecvIdle[0];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[r]) begin
      if (DirRows[r].last) pinned_q.push_back(DirRows[r].want);
      drive_char(DirRows[r].code, DirRows[r].last);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = SendIdle[phase];
      recv_idle_pct = RecvIdle[phase];
      if (phase == 2) hold_asked++;
      texts_done = 0;
      while (texts_done < TextsPerPhase || (phase == 2 && items_sent < ItemsWanted)) begin
        if ($urandom_range(99) < 55) build_guid_text();
        else build_noise_text();
        send_text();
        texts_done++;
      end
    end
    char_if.valid <= 1'b0;

    @(posedge clk_i);
    while (guid_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0 && guid_q.size() == 0) begin
      $display("[guid_hex_text_parser_top] OK");
    end else begin
      $display("[guid_hex_text_parser_top] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/gtp_pkg.sv
src/gtp_char_if.sv
src/gtp_guid_if.sv
src/gtp_char_decode.sv
src/gtp_parse_core.sv
src/guid_hex_text_parser_top.sv
verif/guid_hex_text_parser_top_tb.sv
